FILE: rtl/sfc_aq_pkg.sv
// ----------------------------------------------------------------------------
// sfc_aq_pkg
// shared types, field widths and qualifier codes of the sfc action engine
// ----------------------------------------------------------------------------
package sfc_aq_pkg;

  localparam int IDX_W  = 6;
  localparam int KIND_W = 4;
  localparam int GRP_W  = 6;
  localparam int DUR_W  = 32;
  localparam int DT_W   = 16;
  localparam int OTIM_W = 32;

  localparam int DEF_NUM_ACTIONS = 64;
  localparam int DEF_NUM_STEPS   = 64;
  localparam int DEF_TIMER_BITS  = 32;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;

  // request types
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // action qualifiers
  localparam logic [KIND_W-1:0] Q_N  = 4'd0;
  localparam logic [KIND_W-1:0] Q_S  = 4'd1;
  localparam logic [KIND_W-1:0] Q_R  = 4'd2;
  localparam logic [KIND_W-1:0] Q_D  = 4'd3;
  localparam logic [KIND_W-1:0] Q_L  = 4'd4;
  localparam logic [KIND_W-1:0] Q_SD = 4'd5;
  localparam logic [KIND_W-1:0] Q_DS = 4'd6;
  localparam logic [KIND_W-1:0] Q_SL = 4'd7;
  localparam logic [KIND_W-1:0] Q_P  = 4'd8;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  entry_idx;
    logic [IDX_W-1:0]  step_index;
    logic              step_live;
    logic              last_of_step;
    logic [DT_W-1:0]   tick_delta;
    logic [KIND_W-1:0] load_kind;
    logic [GRP_W-1:0]  load_group;
    logic [DUR_W-1:0]  load_duration;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  out_index;
    logic              out_active;
    logic [OTIM_W-1:0] out_timer;
  } out_item_t;

  // classified item as it sits in the queue
  typedef struct packed {
    in_item_t item;
    logic     ai_ok;
    logic     si_ok;
  } q_item_t;

  // back part status seen by the front
  typedef struct packed {
    logic init_busy;
    logic result_wait;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_WTAIL,
    ST_POST
  } exec_state_t;

endpackage

FILE: rtl/sfc_aq_front.sv
// ----------------------------------------------------------------------------
// sfc_aq_front
// input acceptance and range classification of items
// ----------------------------------------------------------------------------
module sfc_aq_front #(
  parameter int NUM_ACTIONS = sfc_aq_pkg::DEF_NUM_ACTIONS,
  parameter int NUM_STEPS   = sfc_aq_pkg::DEF_NUM_STEPS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sfc_aq_pkg::in_item_t     in_data,
  input  sfc_aq_pkg::back_status_t status,
  input  logic                     q_full,
  output logic                     q_push,
  output sfc_aq_pkg::q_item_t      q_data
);

  localparam int AW = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int SW = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
  localparam int AXW = sfc_aq_pkg::IDX_W + AW + 1;
  localparam int SXW = sfc_aq_pkg::IDX_W + SW + 1;

  logic [AXW-1:0] ai_ext;
  logic [SXW-1:0] si_ext;
  logic           stall_seen_r;

  assign ai_ext = AXW'(in_data.entry_idx);
  assign si_ext = SXW'(in_data.step_index);

  // no items during the clearing pass
  assign in_ready = !status.init_busy && !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_data       = '0;
    q_data.item  = in_data;
    q_data.ai_ok = ai_ext < AXW'(NUM_ACTIONS);
    q_data.si_ok = si_ext < SXW'(NUM_STEPS);
  end

  // flags a queue that fills while the back waits on the receiver
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_seen_r <= 1'b0;
    end else begin
      stall_seen_r <= q_full && status.result_wait;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    stall_seen_r |-> !$past(q_push))
    else $error("item pushed into a full queue");

endmodule

FILE: rtl/sfc_aq_fifo.sv
// ----------------------------------------------------------------------------
// sfc_aq_fifo
// short queue that decouples classification from execution
// ----------------------------------------------------------------------------
module sfc_aq_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sfc_aq_pkg::q_item_t push_data,
  output logic                full,
  input  logic                pop,
  output sfc_aq_pkg::q_item_t pop_data,
  output logic                valid
);

  localparam int DEPTH = sfc_aq_pkg::QDEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  sfc_aq_pkg::q_item_t mem_r [DEPTH];
  logic [PW-1:0]       wr_ptr_r;
  logic [PW-1:0]       rd_ptr_r;
  logic [CW-1:0]       count_r;
  logic                do_push;
  logic                do_pop;

  assign full     = count_r == CW'(DEPTH);
  assign valid    = count_r != '0;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/sfc_aq_exec.sv
// ----------------------------------------------------------------------------
// sfc_aq_exec
// back part: action table, qualifier evaluation, group reset walk, result
// ----------------------------------------------------------------------------
module sfc_aq_exec #(
  parameter int NUM_ACTIONS = sfc_aq_pkg::DEF_NUM_ACTIONS,
  parameter int NUM_STEPS   = sfc_aq_pkg::DEF_NUM_STEPS,
  parameter int TIMER_BITS  = sfc_aq_pkg::DEF_TIMER_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  sfc_aq_pkg::q_item_t      q_data,
  output logic                     q_pop,
  output sfc_aq_pkg::back_status_t status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output sfc_aq_pkg::out_item_t    out_data
);

  localparam int AW   = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int SW   = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
  localparam int TW   = TIMER_BITS;
  localparam int SUMW = ((TW > sfc_aq_pkg::DT_W) ? TW : sfc_aq_pkg::DT_W) + 1;
  localparam int CMPW = (TW > sfc_aq_pkg::DUR_W) ? TW : sfc_aq_pkg::DUR_W;
  localparam int CLR_LEN = (NUM_ACTIONS > NUM_STEPS) ? NUM_ACTIONS : NUM_STEPS;
  localparam int CCW  = $clog2(CLR_LEN + 1);
  localparam int AXW  = sfc_aq_pkg::IDX_W + AW;
  localparam int SXW  = sfc_aq_pkg::IDX_W + SW;

  typedef struct packed {
    logic [sfc_aq_pkg::KIND_W-1:0] kind;
    logic [sfc_aq_pkg::GRP_W-1:0]  group;
    logic [sfc_aq_pkg::DUR_W-1:0]  dur;
  } ent_t;

  function automatic logic is_stored_kind(input logic [sfc_aq_pkg::KIND_W-1:0] k);
    return (k == sfc_aq_pkg::Q_S) || (k == sfc_aq_pkg::Q_SD) ||
           (k == sfc_aq_pkg::Q_DS) || (k == sfc_aq_pkg::Q_SL);
  endfunction

  // memories
  ent_t        ent_mem [NUM_ACTIONS];
  logic [TW:0] tm_mem  [NUM_ACTIONS];
  logic        sm_mem  [NUM_STEPS];

  ent_t        ent_rd_r;
  logic [TW:0] tm_rd_r;
  logic        sm_rd_r;

  logic          ent_we;
  logic [AW-1:0] ent_waddr;
  ent_t          ent_wdata;
  logic [AW-1:0] ent_raddr;
  logic          tm_we;
  logic [AW-1:0] tm_waddr;
  logic [TW:0]   tm_wdata;
  logic [AW-1:0] tm_raddr;
  logic          sm_we;
  logic [SW-1:0] sm_waddr;
  logic          sm_wdata;
  logic [SW-1:0] sm_raddr;

  // control and working registers
  sfc_aq_pkg::exec_state_t state_r, state_nxt;
  sfc_aq_pkg::q_item_t     cur_r;
  logic [CCW-1:0]          clr_cnt_r;
  logic [AW-1:0]           walk_cnt_r;
  logic                    wp_v_r;
  logic [AW-1:0]           wp_addr_r;
  logic [sfc_aq_pkg::GRP_W-1:0] grp_r;
  logic                    res_a_r;
  logic [sfc_aq_pkg::OTIM_W-1:0] res_t_r;
  logic                    out_valid_r;
  sfc_aq_pkg::out_item_t   out_data_r;

  logic [AXW-1:0] hai_ext, cai_ext;
  logic [SXW-1:0] hsi_ext, csi_ext;

  logic          is_eval;
  logic          walk_req;
  logic          walk_last;
  logic          walk_hit;
  logic          clr_last;
  logic          out_load;
  logic          a_new;
  logic [TW-1:0] t_new;
  logic [CMPW-1:0] t_new_ext;

  assign hai_ext = AXW'(q_data.item.entry_idx);
  assign cai_ext = AXW'(cur_r.item.entry_idx);
  assign hsi_ext = SXW'(q_data.item.step_index);
  assign csi_ext = SXW'(cur_r.item.step_index);

  assign is_eval   = cur_r.item.req_type == sfc_aq_pkg::REQ_EVAL;
  assign walk_req  = is_eval && cur_r.ai_ok && (ent_rd_r.kind == sfc_aq_pkg::Q_R) &&
                     cur_r.item.step_live;
  assign walk_last = walk_cnt_r == AW'(NUM_ACTIONS - 1);
  assign walk_hit  = wp_v_r && is_stored_kind(ent_rd_r.kind) && (ent_rd_r.group == grp_r);
  assign clr_last  = clr_cnt_r == CCW'(CLR_LEN - 1);
  assign out_load  = (state_r == sfc_aq_pkg::ST_POST) && (!out_valid_r || out_ready);

  // qualifier evaluation of the current entry
  always_comb begin
    logic          act;
    logic          was;
    logic          rise;
    logic          fall;
    logic          a;
    logic [TW-1:0] t;
    logic [TW-1:0] base;
    logic [SUMW-1:0] sum;
    logic [TW-1:0] tadd;
    logic          ge;
    logic          lt;
    act  = cur_r.item.step_live;
    was  = cur_r.si_ok ? sm_rd_r : 1'b0;
    rise = act && !was;
    fall = !act && was;
    a    = tm_rd_r[TW];
    t    = tm_rd_r[TW-1:0];
    // the SL rising edge restarts the timer before it counts
    base = ((ent_rd_r.kind == sfc_aq_pkg::Q_SL) && rise) ? '0 : t;
    sum  = SUMW'(base) + SUMW'(cur_r.item.tick_delta);
    tadd = (sum > SUMW'({TW{1'b1}})) ? {TW{1'b1}} : sum[TW-1:0];
    ge   = CMPW'(tadd) >= CMPW'(ent_rd_r.dur);
    lt   = CMPW'(t) < CMPW'(ent_rd_r.dur);
    a_new = a;
    t_new = t;
    unique case (ent_rd_r.kind)
      sfc_aq_pkg::Q_N: begin
        a_new = act;
        t_new = act ? t : '0;
      end
      sfc_aq_pkg::Q_S: begin
        if (rise) a_new = 1'b1;
      end
      sfc_aq_pkg::Q_R: begin
        a_new = 1'b0;
      end
      sfc_aq_pkg::Q_D: begin
        a_new = act && ge;
        t_new = act ? tadd : '0;
      end
      sfc_aq_pkg::Q_L: begin
        if (!act) begin
          a_new = 1'b0;
          t_new = '0;
        end else if (lt) begin
          a_new = 1'b1;
          t_new = tadd;
        end else begin
          a_new = 1'b0;
        end
      end
      sfc_aq_pkg::Q_SD: begin
        if (act) begin
          t_new = tadd;
          if (ge) a_new = 1'b1;
        end else if (fall) begin
          t_new = '0;
        end
      end
      sfc_aq_pkg::Q_DS: begin
        if (act) begin
          t_new = tadd;
          if (ge) a_new = 1'b1;
        end else begin
          t_new = '0;
        end
      end
      sfc_aq_pkg::Q_SL: begin
        if (rise || a) begin
          t_new = tadd;
          a_new = !ge;
        end
      end
      sfc_aq_pkg::Q_P: begin
        a_new = rise;
      end
      default: begin
        a_new = a;
      end
    endcase
  end

  assign t_new_ext = CMPW'(t_new);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfc_aq_pkg::ST_INIT:  if (clr_last) state_nxt = sfc_aq_pkg::ST_IDLE;
      sfc_aq_pkg::ST_IDLE:  if (q_valid) state_nxt = sfc_aq_pkg::ST_EXEC;
      sfc_aq_pkg::ST_EXEC:  state_nxt = walk_req ? sfc_aq_pkg::ST_WALK : sfc_aq_pkg::ST_POST;
      sfc_aq_pkg::ST_WALK:  if (walk_last) state_nxt = sfc_aq_pkg::ST_WTAIL;
      sfc_aq_pkg::ST_WTAIL: state_nxt = sfc_aq_pkg::ST_POST;
      sfc_aq_pkg::ST_POST:  if (out_load) state_nxt = sfc_aq_pkg::ST_IDLE;
      default:              state_nxt = sfc_aq_pkg::ST_INIT;
    endcase
  end

  // memory ports and queue control
  always_comb begin
    q_pop     = 1'b0;
    ent_we    = 1'b0;
    ent_waddr = cai_ext[AW-1:0];
    ent_wdata = '{kind:  cur_r.item.load_kind,
                  group: cur_r.item.load_group,
                  dur:   cur_r.item.load_duration};
    ent_raddr = hai_ext[AW-1:0];
    tm_we     = 1'b0;
    tm_waddr  = cai_ext[AW-1:0];
    tm_wdata  = '0;
    tm_raddr  = hai_ext[AW-1:0];
    sm_we     = 1'b0;
    sm_waddr  = csi_ext[SW-1:0];
    sm_wdata  = cur_r.item.step_live;
    sm_raddr  = hsi_ext[SW-1:0];
    unique case (state_r)
      sfc_aq_pkg::ST_INIT: begin
        tm_we    = clr_cnt_r < CCW'(NUM_ACTIONS);
        tm_waddr = clr_cnt_r[AW-1:0];
        sm_we    = clr_cnt_r < CCW'(NUM_STEPS);
        sm_waddr = clr_cnt_r[SW-1:0];
        sm_wdata = 1'b0;
      end
      sfc_aq_pkg::ST_IDLE: begin
        q_pop = q_valid;
      end
      sfc_aq_pkg::ST_EXEC: begin
        if (!is_eval) begin
          ent_we = cur_r.ai_ok;
          tm_we  = cur_r.ai_ok;
        end else begin
          tm_we    = cur_r.ai_ok;
          tm_wdata = {a_new, t_new};
          sm_we    = cur_r.item.last_of_step && cur_r.si_ok;
        end
      end
      sfc_aq_pkg::ST_WALK: begin
        ent_raddr = walk_cnt_r;
        tm_we     = walk_hit;
        tm_waddr  = wp_addr_r;
      end
      sfc_aq_pkg::ST_WTAIL: begin
        tm_we    = walk_hit;
        tm_waddr = wp_addr_r;
      end
      sfc_aq_pkg::ST_POST: begin
        q_pop = 1'b0;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rd_r <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (tm_we) tm_mem[tm_waddr] <= tm_wdata;
    tm_rd_r <= tm_mem[tm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) sm_mem[sm_waddr] <= sm_wdata;
    sm_rd_r <= sm_mem[sm_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
    if (state_r == sfc_aq_pkg::ST_EXEC) begin
      grp_r   <= ent_rd_r.group;
      res_a_r <= is_eval && cur_r.ai_ok && a_new;
      res_t_r <= (is_eval && cur_r.ai_ok) ? t_new_ext[sfc_aq_pkg::OTIM_W-1:0] : '0;
    end
    wp_addr_r <= walk_cnt_r;
    if (out_load) begin
      out_data_r.out_index  <= cur_r.item.entry_idx;
      out_data_r.out_active <= res_a_r;
      out_data_r.out_timer  <= res_t_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfc_aq_pkg::ST_INIT;
      clr_cnt_r   <= '0;
      walk_cnt_r  <= '0;
      wp_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == sfc_aq_pkg::ST_INIT) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == sfc_aq_pkg::ST_EXEC) begin
        walk_cnt_r <= '0;
      end else if (state_r == sfc_aq_pkg::ST_WALK) begin
        walk_cnt_r <= walk_cnt_r + 1'b1;
      end
      wp_v_r <= state_r == sfc_aq_pkg::ST_WALK;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data           = out_data_r;
  assign status.init_busy   = state_r == sfc_aq_pkg::ST_INIT;
  assign status.result_wait = (state_r == sfc_aq_pkg::ST_POST) && !out_load;

  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == sfc_aq_pkg::ST_IDLE) && q_valid)
    else $error("queue popped outside idle");

  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && (state_r != sfc_aq_pkg::ST_POST)) |=> !out_valid_r)
    else $error("result presented without a finished item");

  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == sfc_aq_pkg::ST_EXEC) && (state_nxt == sfc_aq_pkg::ST_WALK)) |=>
      (walk_cnt_r == '0))
    else $error("group reset walk does not start at entry zero");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sfc_aq_pkg::ST_WTAIL) |-> $past(state_r == sfc_aq_pkg::ST_WALK) && wp_v_r)
    else $error("walk tail without a pending table entry");

endmodule

FILE: rtl/sfc_action_qualifier_engine_core.sv
// ----------------------------------------------------------------------------
// sfc_action_qualifier_engine_core
// sfc action table with iec qualifier evaluation (n s r d l sd ds sl p)
// ----------------------------------------------------------------------------
// usage
//   in channel  : in_valid/in_ready carry one item; req_type load fills an
//                 entry, req_type eval applies the entry's qualifier for one
//                 tick using step_live, the stored step flag and tick_delta
//   out channel : out_valid/out_ready carry one result item per input item,
//                 in input order: index, active bit and timer after the item
// back part sequence
//   an item passes the back part as pop and table read, then evaluate and
//   write back, then result register; an active r action adds a group
//   reset walk over the table port, one entry per cycle, and a walk tail
//   before the result register; out_valid rises as the result register
//   is loaded
// reset
//   after rst_n a clearing pass zeroes timers, active bits and step
//   flags; in_ready stays low during it
// stall
//   a waiting result holds the back part in its result stage until out_ready,
//   a two-item queue keeps the front accepting until it fills, then in_ready
//   drops
// ----------------------------------------------------------------------------
module sfc_action_qualifier_engine_core #(
  parameter int NUM_ACTIONS = sfc_aq_pkg::DEF_NUM_ACTIONS,
  parameter int NUM_STEPS   = sfc_aq_pkg::DEF_NUM_STEPS,
  parameter int TIMER_BITS  = sfc_aq_pkg::DEF_TIMER_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sfc_aq_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sfc_aq_pkg::out_item_t out_data
);

  // front to queue
  logic                     q_push;
  logic                     q_full;
  sfc_aq_pkg::q_item_t      q_push_data;
  // queue to back
  logic                     q_pop;
  logic                     q_valid;
  sfc_aq_pkg::q_item_t      q_head;
  // back status toward front
  sfc_aq_pkg::back_status_t status;

  // accept and classify range of action and step index
  sfc_aq_front #(
    .NUM_ACTIONS (NUM_ACTIONS),
    .NUM_STEPS   (NUM_STEPS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .status   (status),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  // decoupling queue
  sfc_aq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .valid     (q_valid)
  );

  // table, evaluation, group reset walk and result register
  sfc_aq_exec #(
    .NUM_ACTIONS (NUM_ACTIONS),
    .NUM_STEPS   (NUM_STEPS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
